/* design/knvs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// knvs_pkg
// Shared types and constants for the nearest value selector.
// ----------------------------------------------------------------------------
package knvs_pkg;

	localparam int MAX_KEEP_DEF = 16;
	localparam int VALUE_W      = 32;
	localparam int TARGET_W     = 40;
	localparam int KEEP_W       = 7;
	localparam int DIST_W       = 41;
	localparam int FRAC_W       = 8;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 40;

	localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEEP   = 2'd1;

	typedef struct packed {
		logic signed [VALUE_W-1:0] sample_value;
		logic                      is_final;
	} item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] chosen_value;
		logic                      end_of_run;
	} result_t;

	typedef struct packed {
		logic [DIST_W-1:0]         span;
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} work_t;

endpackage
`default_nettype wire

/* design/knvs_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// knvs_front
// Captures an input beat and computes its distance to the target.
// ----------------------------------------------------------------------------
module knvs_front (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire knvs_pkg::item_t                        item,
	input  wire logic signed [knvs_pkg::TARGET_W-1:0]   target,
	output logic                                        push,
	output knvs_pkg::work_t                             push_data,
	input  wire logic                                   full
);

	logic                  valid_s1;
	knvs_pkg::item_t       item_s1;
	logic                  take;
	logic signed [41:0]    diff;
	logic signed [41:0]    neg;

	assign busy = valid_s1 && full;
	assign take = start && !busy;
	assign push = valid_s1 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	always_comb begin
		diff = {{2{item_s1.sample_value[knvs_pkg::VALUE_W-1]}}, item_s1.sample_value,
			{knvs_pkg::FRAC_W{1'b0}}} - {{2{target[knvs_pkg::TARGET_W-1]}}, target};
		neg  = -diff;
		push_data.span  = diff[41] ? neg[knvs_pkg::DIST_W-1:0] : diff[knvs_pkg::DIST_W-1:0];
		push_data.value = item_s1.sample_value;
		push_data.last  = item_s1.is_final;
	end

endmodule
`default_nettype wire

/* design/knvs_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// knvs_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module knvs_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire knvs_pkg::work_t  push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  not_empty,
	output knvs_pkg::work_t       pop_data
);

	knvs_pkg::work_t mem [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            do_pop;

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

/* design/knvs_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// knvs_back
// Sorted store of the kept values, one insertion per cycle outside a drain,
// and the drain that emits them farthest first.
// ----------------------------------------------------------------------------
module knvs_back #(
	parameter int MAX_KEEP = knvs_pkg::MAX_KEEP_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [knvs_pkg::KEEP_W-1:0]      keep,
	input  wire logic                             avail,
	input  wire knvs_pkg::work_t                  work,
	output logic                                  pop,
	output knvs_pkg::result_t                     result,
	output logic                                  result_strobe
);

	localparam int CNT_W = $clog2(MAX_KEEP + 1);
	localparam int IDX_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

	localparam logic ST_RUN   = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic [knvs_pkg::DIST_W-1:0]          dist_q [MAX_KEEP];
	logic signed [knvs_pkg::VALUE_W-1:0]  num_q  [MAX_KEEP];
	logic [CNT_W-1:0]                     held_q;
	logic                                 state_q;
	logic [IDX_W-1:0]                     drain_q;
	knvs_pkg::result_t                    result_q;
	logic                                 strobe_q;

	logic [CNT_W-1:0]    k_eff;
	logic [CNT_W-1:0]    n;
	logic [CNT_W-1:0]    n_new;
	logic [MAX_KEEP-1:0] gt;
	logic                do_ins;
	logic                room;

	assign pop           = (state_q == ST_RUN) && avail;
	assign result        = result_q;
	assign result_strobe = strobe_q;

	always_comb begin
		if (keep > knvs_pkg::KEEP_W'(MAX_KEEP)) begin
			k_eff = CNT_W'(MAX_KEEP);
		end else begin
			k_eff = CNT_W'(keep);
		end
		n      = (held_q < k_eff) ? held_q : k_eff;
		room   = n < k_eff;
		do_ins = room || (|gt);
		n_new  = room ? n + CNT_W'(1) : n;
	end

	for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
		logic take_new;
		logic shift_in;

		assign gt[i] = (CNT_W'(i) < n) && (dist_q[i] > work.span);

		if (i == 0) begin : g_first
			assign take_new = gt[0] || (n == CNT_W'(0));
			assign shift_in = 1'b0;
		end else begin : g_rest
			assign take_new = !gt[i-1] && (gt[i] || (n == CNT_W'(i)));
			assign shift_in = gt[i-1];
		end

		always_ff @(posedge clk) begin
			if (pop && do_ins) begin
				if (take_new) begin
					dist_q[i] <= work.span;
					num_q[i]  <= work.value;
				end else if (shift_in) begin
					if (i > 0) begin
						dist_q[i] <= dist_q[(i > 0) ? i - 1 : 0];
						num_q[i]  <= num_q[(i > 0) ? i - 1 : 0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= '0;
			state_q  <= ST_RUN;
			drain_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (state_q == ST_DRAIN);
			case (state_q)
				ST_RUN: begin
					if (pop) begin
						held_q <= n_new;
						if (work.last && (n_new != CNT_W'(0))) begin
							drain_q <= IDX_W'(n_new - CNT_W'(1));
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (drain_q == IDX_W'(0)) begin
						held_q  <= '0;
						state_q <= ST_RUN;
					end else begin
						drain_q <= drain_q - IDX_W'(1);
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DRAIN) begin
			result_q.chosen_value <= num_q[drain_q];
			result_q.end_of_run   <= drain_q == IDX_W'(0);
		end
	end

endmodule
`default_nettype wire

/* design/k_nearest_value_select.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// k_nearest_value_select
// Keeps the configured number of values nearest to a fixed-point target and
// emits them farthest first when the final beat of a set arrives.
// ----------------------------------------------------------------------------
// Path: a beat is registered in the front, held in the queue and then inserted
// in the sorted store; after a final beat the drain registers each result.
// Throughput: one beat per cycle outside a drain, set by the insertion chain.
// A final beat starts a drain of min(count, k) values; meanwhile beats collect
// in the queue, and busy rises once it and the front are full. Results cannot
// be stalled. Reset clears control and target and sets keep to one.
module k_nearest_value_select #(
	parameter int MAX_KEEP = knvs_pkg::MAX_KEEP_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire knvs_pkg::item_t                      item,
	output knvs_pkg::result_t                         result,
	output logic                                      result_strobe,
	input  wire logic                                 cfg_we,
	input  wire logic [knvs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [knvs_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic signed [knvs_pkg::TARGET_W-1:0] target_q;
	logic [knvs_pkg::KEEP_W-1:0]          keep_q;
	logic                                 push;
	knvs_pkg::work_t                      push_data;
	logic                                 full;
	logic                                 pop;
	logic                                 not_empty;
	knvs_pkg::work_t                      pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			keep_q   <= knvs_pkg::KEEP_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				knvs_pkg::REG_TARGET: target_q <= cfg_data[knvs_pkg::TARGET_W-1:0];
				knvs_pkg::REG_KEEP:   keep_q   <= cfg_data[knvs_pkg::KEEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	knvs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.target    (target_q),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	knvs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_data  (pop_data)
	);

	knvs_back #(
		.MAX_KEEP (MAX_KEEP)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.keep          (keep_q),
		.avail         (not_empty),
		.work          (pop_data),
		.pop           (pop),
		.result        (result),
		.result_strobe (result_strobe)
	);

endmodule
`default_nettype wire

/* dv/k_nearest_value_select_test.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// k_nearest_value_select_test
// Self-checking bench for the nearest value selector. A directed table runs
// first: extremes, ties, the zero and saturated keep counts, ignored register
// indexes and a keep count lowered in the middle of a set. Random sets follow
// under changing targets and keep counts, with random gaps between beats.
// Each result is checked against a behavioral model or a value in the table.
// ----------------------------------------------------------------------------
module k_nearest_value_select_test;

	localparam int CAP          = knvs_pkg::MAX_KEEP_DEF;
	localparam int SETTLE       = 8;
	localparam int RANDOM_ITEMS = 345;
	localparam int MAX_SHOWN    = 10;
	localparam int LIMIT_CYCLES = 400000;

	localparam logic [knvs_pkg::CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
	localparam logic [knvs_pkg::CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

	typedef logic [knvs_pkg::CFG_DATA_W-1:0] cfg_word_t;

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t                           kind;
		logic [knvs_pkg::CFG_IDX_W-1:0]      index;
		logic [knvs_pkg::CFG_DATA_W-1:0]     data;
		logic signed [knvs_pkg::VALUE_W-1:0] value;
		logic                                last;
		logic                                typed;
		logic signed [knvs_pkg::VALUE_W-1:0] want;
	} row_t;

	logic                            clk;
	logic                            arst_n    = 1'b0;
	logic                            start     = 1'b0;
	knvs_pkg::item_t                 item      = '0;
	logic                            cfg_we    = 1'b0;
	logic [knvs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [knvs_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
	logic                            busy;
	knvs_pkg::result_t               result;
	logic                            result_strobe;

	logic [knvs_pkg::DIST_W-1:0]          near_dist [CAP];
	logic signed [knvs_pkg::VALUE_W-1:0]  near_val [CAP];
	int                                   near_cnt = 0;
	logic signed [knvs_pkg::TARGET_W-1:0] goal     = '0;
	logic [knvs_pkg::KEEP_W-1:0]          keep_cfg = 7'd1;

	knvs_pkg::result_t pending_picks [$];
	knvs_pkg::result_t fresh_picks [$];
	row_t              plan [$];

	int fails    = 0;
	int shown    = 0;
	int n_items  = 0;
	int n_sets   = 0;
	int n_picks  = 0;
	int n_writes = 0;

	k_nearest_value_select uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result       (result),
		.result_strobe(result_strobe),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * LIMIT_CYCLES);
		$display("Timed out with %0d result beats still expected.", pending_picks.size());
		$display("TEST FAILED");
		$finish;
	end

	function automatic void fold_sample(input knvs_pkg::item_t it);
		int     k;
		int     n;
		int     pos;
		int     r;
		longint diff;
		logic [knvs_pkg::DIST_W-1:0] d;
		k = (keep_cfg > CAP) ? CAP : int'(keep_cfg);
		n = (near_cnt < k) ? near_cnt : k;
		diff = longint'(it.sample_value) * 256 - longint'(goal);
		if (diff < 0) begin
			diff = -diff;
		end
		d = diff[knvs_pkg::DIST_W-1:0];
		fresh_picks.delete();
		if (n < k || (n > 0 && d < near_dist[n-1])) begin
			if (n == k) begin
				n--;
			end
			pos = n;
			while (pos > 0 && near_dist[pos-1] > d) begin
				near_dist[pos] = near_dist[pos-1];
				near_val[pos]  = near_val[pos-1];
				pos--;
			end
			near_dist[pos] = d;
			near_val[pos]  = it.sample_value;
			n++;
		end
		near_cnt = n;
		if (it.is_final) begin
			for (r = n - 1; r >= 0; r--) begin
				fresh_picks.insert(fresh_picks.size(),
					knvs_pkg::result_t'{near_val[r], r == 0});
			end
			near_cnt = 0;
		end
	endfunction

	task automatic note_miss(input string what, input knvs_pkg::result_t want,
			input knvs_pkg::result_t got);
		fails++;
		if (shown < MAX_SHOWN) begin
			shown++;
			$display("Mismatch at %0t (%s): expected value %0d end %0b, got value %0d end %0b",
				$time, what, want.chosen_value, want.end_of_run, got.chosen_value,
				got.end_of_run);
		end
	endtask

	always @(posedge clk) begin : watch
		knvs_pkg::result_t want;
		if (arst_n && result_strobe) begin
			n_picks++;
			if (pending_picks.size() == 0) begin
				note_miss("no beat expected", '0, result);
			end else begin
				want = pending_picks.pop_front();
				if (result.chosen_value !== want.chosen_value ||
						result.end_of_run !== want.end_of_run) begin
					note_miss("wrong field", want, result);
				end
			end
		end
	end

	task automatic offer(input knvs_pkg::item_t it, input int gap, input logic typed,
			input logic signed [knvs_pkg::VALUE_W-1:0] want);
		int i;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
		fold_sample(it);
		if (typed) begin
			pending_picks.insert(pending_picks.size(), knvs_pkg::result_t'{want, 1'b1});
		end else begin
			for (i = 0; i < fresh_picks.size(); i++) begin
				pending_picks.insert(pending_picks.size(), fresh_picks[i]);
			end
		end
		n_items++;
		if (it.is_final) begin
			n_sets++;
		end
	endtask

	// Registers change only once the block has drained and gone quiet.
	task automatic write_reg(input logic [knvs_pkg::CFG_IDX_W-1:0] idx,
			input logic [knvs_pkg::CFG_DATA_W-1:0] val);
		start <= 1'b0;
		while (pending_picks.size() != 0 || busy) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == knvs_pkg::REG_TARGET) begin
			goal = val;
		end else if (idx == knvs_pkg::REG_KEEP) begin
			keep_cfg = val[knvs_pkg::KEEP_W-1:0];
		end
		n_writes++;
	endtask

	function automatic void add_item(input logic signed [knvs_pkg::VALUE_W-1:0] v,
			input logic last);
		plan.insert(plan.size(), row_t'{ROW_ITEM, knvs_pkg::REG_TARGET, '0, v, last, 1'b0, '0});
	endfunction

	function automatic void add_check(input logic signed [knvs_pkg::VALUE_W-1:0] v,
			input logic signed [knvs_pkg::VALUE_W-1:0] want);
		plan.insert(plan.size(), row_t'{ROW_ITEM, knvs_pkg::REG_TARGET, '0, v, 1'b1, 1'b1, want});
	endfunction

	function automatic void add_write(input logic [knvs_pkg::CFG_IDX_W-1:0] idx,
			input logic [knvs_pkg::CFG_DATA_W-1:0] val);
		plan.insert(plan.size(), row_t'{ROW_WRITE, idx, val, '0, 1'b0, 1'b0, '0});
	endfunction

	function automatic void load_plan();
		add_check(32'sd5, 32'sd5);
		add_item(32'sh7FFFFFFF, 1'b0);
		add_check(32'sh80000000, 32'sh7FFFFFFF);
		add_item(-32'sd3, 1'b0);
		add_check(32'sd3, -32'sd3);
		add_write(REG_SPARE2, '1);
		add_write(REG_SPARE3, '1);
		add_item(32'sd9, 1'b0);
		add_check(32'sd2, 32'sd2);
		add_write(knvs_pkg::REG_TARGET, 40'h7F_FFFF_FFFF);
		add_write(knvs_pkg::REG_KEEP, 40'd127);
		add_item(32'sh7FFFFFFF, 1'b0);
		add_item(32'sh80000000, 1'b0);
		add_item(32'sd0, 1'b0);
		add_item(-32'sd1, 1'b0);
		add_item(32'sd1, 1'b0);
		add_item(32'sh7FFFFFFF, 1'b1);
		add_write(knvs_pkg::REG_TARGET, 40'h80_0000_0000);
		add_write(knvs_pkg::REG_KEEP, 40'd0);
		add_item(32'sd7, 1'b1);
		add_write(knvs_pkg::REG_TARGET, 40'h180);
		add_write(knvs_pkg::REG_KEEP, 40'd5);
		add_item(32'sd1, 1'b0);
		add_item(32'sd2, 1'b0);
		add_item(32'sd0, 1'b0);
		add_item(32'sd3, 1'b0);
		add_write(knvs_pkg::REG_KEEP, 40'd2);
		add_item(32'sd4, 1'b0);
		add_item(32'sd1, 1'b1);
		add_write(knvs_pkg::REG_KEEP, 40'd64);
		add_write(knvs_pkg::REG_TARGET, 40'hFF_FFFF_FF80);
		add_item(32'sd0, 1'b0);
		add_item(-32'sd1, 1'b1);
	endfunction

	function automatic logic [knvs_pkg::CFG_DATA_W-1:0] draw_target();
		longint t;
		case ($urandom_range(0, 5))
			0: t = {$urandom, $urandom};
			1: t = $urandom_range(0, 1) ? 64'sh7F_FFFF_FFFF : -64'sh80_0000_0000;
			default: t = (longint'(int'($urandom_range(0, 4000)) - 2000) <<< knvs_pkg::FRAC_W) |
				longint'($urandom_range(0, 255));
		endcase
		case ($urandom_range(0, 2))
			0: t[knvs_pkg::FRAC_W-1:0] = 8'h00;
			1: t[knvs_pkg::FRAC_W-1:0] = 8'h80;
			default: ;
		endcase
		return t[knvs_pkg::CFG_DATA_W-1:0];
	endfunction

	function automatic logic [knvs_pkg::CFG_DATA_W-1:0] draw_keep();
		case ($urandom_range(0, 11))
			0: return 40'd1;
			1: return 40'd0;
			2: return 40'd64;
			3: return 40'd127;
			4: return cfg_word_t'(CAP);
			5: return cfg_word_t'(CAP + 1);
			default: return cfg_word_t'($urandom_range(1, CAP));
		endcase
	endfunction

	function automatic logic signed [knvs_pkg::VALUE_W-1:0] draw_sample(
			input logic signed [knvs_pkg::VALUE_W-1:0] recent);
		logic signed [knvs_pkg::VALUE_W-1:0] centre;
		centre = goal[knvs_pkg::TARGET_W-1:knvs_pkg::FRAC_W];
		case ($urandom_range(0, 9))
			0, 1, 2: return $urandom;
			3: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
			4: return recent;
			default: return centre + (int'($urandom_range(0, 16)) - 8);
		endcase
	endfunction

	initial begin : main
		knvs_pkg::item_t it;
		int    i;
		int    j;
		int    len;
		int    stop_at;
		logic  burst;
		logic signed [knvs_pkg::VALUE_W-1:0] recent;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_plan();
		for (i = 0; i < plan.size(); i++) begin
			if (plan[i].kind == ROW_WRITE) begin
				write_reg(plan[i].index, plan[i].data);
			end else begin
				it.sample_value = plan[i].value;
				it.is_final     = plan[i].last;
				offer(it, $urandom_range(0, 19), plan[i].typed, plan[i].want);
			end
		end

		recent  = '0;
		stop_at = n_items + RANDOM_ITEMS;
		while (n_items < stop_at) begin
			write_reg(knvs_pkg::REG_TARGET, draw_target());
			write_reg(knvs_pkg::REG_KEEP, draw_keep());
			burst = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(2, 4)) begin
				case ($urandom_range(0, 9))
					0: len = 1;
					1: len = $urandom_range(CAP + 1, 40);
					default: len = $urandom_range(2, CAP);
				endcase
				for (j = 0; j < len; j++) begin
					it.sample_value = draw_sample(recent);
					it.is_final     = (j == len - 1);
					recent          = it.sample_value;
					offer(it, burst ? 0 : $urandom_range(0, 19), 1'b0, '0);
				end
			end
		end

		start <= 1'b0;
		while (pending_picks.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Ran %0d beats in %0d sets under %0d register writes.",
			n_items, n_sets, n_writes);
		$display("Checked %0d result beats, %0d mismatches.", n_picks, fails);
		if (fails == 0 && pending_picks.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
